// ===== design/ils_pkg.sv =====
package ils_pkg;

	localparam int CAPACITY = 64;
	localparam int ELEM_W   = 32;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int OP_W     = 3;
	localparam int ST_W     = 2;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	// opcodes
	localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
	localparam logic [OP_W-1:0] OP_GET     = 3'd1;
	localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
	localparam logic [OP_W-1:0] OP_PUT     = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;
	localparam logic [OP_W-1:0] OP_REMOVE  = 3'd5;
	localparam logic [OP_W-1:0] OP_INSERT  = 3'd6;

	// status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd1;
	localparam logic [ST_W-1:0] ST_BELOW   = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

	// command broadcast to every cell of the row
	typedef struct packed {
		logic             en;
		logic [OP_W-1:0]  op;
		logic [CNT_W-1:0] idx;
		logic [CNT_W-1:0] cnt;
		logic [ELEM_W-1:0] value;
	} cell_cmd_t;

endpackage

// ===== design/ils_cell.sv =====
// One entry of the list: decides from the broadcast command and its own
// position whether to hold, load the word, zero, or take a neighbor.
module ils_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ils_pkg::IDX_W-1:0]  cell_idx,
	input  ils_pkg::cell_cmd_t         cmd,
	input  logic [ils_pkg::ELEM_W-1:0] left_val,
	input  logic [ils_pkg::ELEM_W-1:0] right_val,
	output logic [ils_pkg::ELEM_W-1:0] entry
);

	logic [ils_pkg::ELEM_W-1:0] entry_q;
	logic [ils_pkg::ELEM_W-1:0] entry_d;
	logic [ils_pkg::CNT_W-1:0]  pos;

	assign pos = {1'b0, cell_idx};

	always_comb begin
		entry_d = entry_q;
		if (cmd.en) begin
			unique case (cmd.op)
				ils_pkg::OP_APPEND: begin
					if (pos == cmd.cnt) entry_d = cmd.value;
				end
				ils_pkg::OP_REPLACE: begin
					if (pos == cmd.idx) entry_d = cmd.value;
				end
				ils_pkg::OP_PUT: begin
					if (pos == cmd.idx) entry_d = cmd.value;
					else if (pos >= cmd.cnt && pos < cmd.idx) entry_d = '0;
				end
				ils_pkg::OP_CLEAR: begin
					if (pos == cmd.idx) entry_d = '0;
				end
				ils_pkg::OP_REMOVE: begin
					if (pos >= cmd.idx && pos < cmd.cnt) begin
						if (pos == cmd.cnt - ils_pkg::CNT_W'(1)) entry_d = '0;
						else entry_d = right_val;
					end
				end
				ils_pkg::OP_INSERT: begin
					if (pos == cmd.idx) entry_d = cmd.value;
					else if (pos > cmd.idx && pos <= cmd.cnt) entry_d = left_val;
				end
				default: entry_d = entry_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) entry_q <= '0;
		else entry_q <= entry_d;
	end

	assign entry = entry_q;

endmodule

// ===== design/indexed_list_store_unit.sv =====
// channel | handshake           | payload
// --------+---------------------+------------------------------
// in      | in_valid / in_ready | opcode, index, value
// out     | out_valid/out_ready | status, read_value, count
//
// One word per cycle while no result stalls: the row of cells updates
// every entry in parallel, so append, put, remove and insert all finish
// in the cycle taken; the output register holds the result the cycle after.
// Reset clears every entry and the used count at once.
// in_ready drops only while a result waits and out_ready is low.
module indexed_list_store_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [ils_pkg::OP_W-1:0]   opcode,
	input  logic [ils_pkg::IDX_W-1:0]  index,
	input  logic [ils_pkg::ELEM_W-1:0] value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [ils_pkg::ST_W-1:0]   status,
	output logic [ils_pkg::ELEM_W-1:0] read_value,
	output logic [ils_pkg::CNT_W-1:0]  count
);

	logic                       fire;
	logic [ils_pkg::CNT_W-1:0]  used_q;
	logic [ils_pkg::CNT_W-1:0]  used_d;
	logic [ils_pkg::CNT_W-1:0]  idx_ext;
	logic                       idx_used;
	logic                       full;
	logic [ils_pkg::ST_W-1:0]   st;
	logic [ils_pkg::ELEM_W-1:0] rd;
	ils_pkg::cell_cmd_t         cmd;

	logic                       out_valid_q;
	logic [ils_pkg::ST_W-1:0]   status_q;
	logic [ils_pkg::ELEM_W-1:0] read_value_q;
	logic [ils_pkg::CNT_W-1:0]  count_q;

	logic [ils_pkg::ELEM_W-1:0] cell_val [ils_pkg::CAPACITY];

	// take a new word whenever the output register is empty or draining
	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;

	assign idx_ext  = {1'b0, index};
	assign idx_used = idx_ext < used_q;
	assign full     = used_q == ils_pkg::CAP_CNT;

	// status decode
	always_comb begin
		st = ils_pkg::ST_OK;
		unique case (opcode) inside
			ils_pkg::OP_APPEND: begin
				if (full) st = ils_pkg::ST_FULL;
			end
			ils_pkg::OP_GET, ils_pkg::OP_REPLACE, ils_pkg::OP_CLEAR,
			ils_pkg::OP_REMOVE: begin
				if (!idx_used) st = ils_pkg::ST_OUTSIDE;
			end
			ils_pkg::OP_PUT: begin
				if (idx_used) st = ils_pkg::ST_BELOW;
				else if (idx_ext >= ils_pkg::CAP_CNT) st = ils_pkg::ST_FULL;
			end
			ils_pkg::OP_INSERT: begin
				if (!idx_used) st = ils_pkg::ST_OUTSIDE;
				else if (full) st = ils_pkg::ST_FULL;
			end
			default: st = ils_pkg::ST_OK;
		endcase
	end

	// broadcast the command; cells act only on a successful word
	always_comb begin
		cmd.en    = fire && (st == ils_pkg::ST_OK);
		cmd.op    = opcode;
		cmd.idx   = idx_ext;
		cmd.cnt   = used_q;
		cmd.value = value;
	end

	// next used count
	always_comb begin
		used_d = used_q;
		if (cmd.en) begin
			unique case (opcode) inside
				ils_pkg::OP_APPEND, ils_pkg::OP_INSERT:
					used_d = used_q + ils_pkg::CNT_W'(1);
				ils_pkg::OP_PUT:
					used_d = idx_ext + ils_pkg::CNT_W'(1);
				ils_pkg::OP_REMOVE:
					used_d = used_q - ils_pkg::CNT_W'(1);
				default:
					used_d = used_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) used_q <= '0;
		else used_q <= used_d;
	end

	// the row of cells; the ends see zero beyond the edge
	for (genvar k = 0; k < ils_pkg::CAPACITY; k++) begin : g_cell
		logic [ils_pkg::ELEM_W-1:0] left_v;
		logic [ils_pkg::ELEM_W-1:0] right_v;

		if (k == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = cell_val[k-1];
		end
		if (k == ils_pkg::CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = cell_val[k+1];
		end

		ils_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_idx  (ils_pkg::IDX_W'(k)),
			.cmd       (cmd),
			.left_val  (left_v),
			.right_val (right_v),
			.entry     (cell_val[k])
		);
	end

	// get: each cell drives the read bus only when selected
	always_comb begin
		rd = '0;
		for (int k = 0; k < ils_pkg::CAPACITY; k++) begin
			if (index == ils_pkg::IDX_W'(k)) rd = rd | cell_val[k];
		end
		if (!(opcode == ils_pkg::OP_GET && idx_used)) rd = '0;
	end

	// output register: hold while stalled, load on every taken word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= fire;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q     <= st;
			read_value_q <= rd;
			count_q      <= used_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count      = count_q;

	// used count never passes capacity
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= ils_pkg::CAP_CNT)
		else $error("used count beyond capacity");

	// a nonzero read only comes with an ok status
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (read_value != '0) |-> status == ils_pkg::ST_OK)
		else $error("read value with error status");

	// a taken append below capacity grows the list by one
	a_append_grow: assert property (@(posedge clk) disable iff (!arst_n)
		fire && opcode == ils_pkg::OP_APPEND && !full
		|=> used_q == $past(used_q) + ils_pkg::CNT_W'(1))
		else $error("append did not grow the list");

	// the reported count matches the stored count after the word
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> count == used_q)
		else $error("reported count differs from stored count");

endmodule
